>>> hw/rtl/phcm_pkg.sv
// Package for the pixel hit charge merger: field widths, beat layouts and the
// command and result types shared by the front end, the queue and the table engine.
// No dependencies.
package phcm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int SENSOR_W = 12;
	localparam int FE_W     = 4;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 7;
	localparam int HIT_Q_W  = 20;
	localparam int CHARGE_W = 24;
	localparam int SRC_W    = 16;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam int PDATA_W    = 32;
	localparam int PADDR_W    = 2;

	localparam logic [PADDR_W-1:0] REG_CHARGE_THRESHOLD = 2'd0;

	localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

	typedef enum logic {
		OP_HIT   = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_id;
		logic [FE_W-1:0]     front_end;
		logic [COL_W-1:0]    column;
		logic [ROW_W-1:0]    row;
	} key_t;

	// Input beat layout, lowest field in the lowest bits.
	typedef struct packed {
		logic [5:0]          pad;
		logic [SRC_W-1:0]    mc_index;
		logic [HIT_Q_W-1:0]  charge;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    column;
		logic [FE_W-1:0]     front_end;
		logic [SENSOR_W-1:0] sensor_id;
	} in_beat_t;

	// Output beat layout, lowest field in the lowest bits.
	typedef struct packed {
		logic                pad;
		logic                overflowed;
		logic [SRC_W-1:0]    first_source;
		logic [CHARGE_W-1:0] charge;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    column;
		logic [FE_W-1:0]     front_end;
		logic [SENSOR_W-1:0] sensor_id;
	} out_beat_t;

	typedef struct packed {
		op_t                op;
		key_t               key;
		logic [HIT_Q_W-1:0] charge;
		logic [SRC_W-1:0]   src;
	} cmd_t;

	typedef struct packed {
		key_t                key;
		logic [CHARGE_W-1:0] charge;
		logic [SRC_W-1:0]    src;
	} entry_t;

	typedef struct packed {
		logic                out_valid;
		key_t                key;
		logic [CHARGE_W-1:0] charge;
		logic [SRC_W-1:0]    first_source;
		logic                overflowed;
		logic                last;
	} result_t;

endpackage

>>> hw/rtl/phcm_front.sv
// Front end of the pixel hit charge merger: takes input beats, decodes them into
// commands and hands them to the command queue. Depends on phcm_pkg.
module phcm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [phcm_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tuser,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output phcm_pkg::cmd_t                    cmd
);

	phcm_pkg::in_beat_t beat;
	phcm_pkg::cmd_t     dec;
	logic               vld_s1;
	phcm_pkg::cmd_t     cmd_s1;

	assign beat = phcm_pkg::in_beat_t'(s_tdata);

	// A flush carries nothing but its kind, so its other fields are cleared.
	always_comb begin
		dec = '0;
		if (s_tuser) begin
			dec.op = phcm_pkg::OP_FLUSH;
		end else begin
			dec.op            = phcm_pkg::OP_HIT;
			dec.key.sensor_id = beat.sensor_id;
			dec.key.front_end = beat.front_end;
			dec.key.column    = beat.column;
			dec.key.row       = beat.row;
			dec.charge        = beat.charge;
			dec.src           = beat.mc_index;
		end
	end

	assign s_tready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cmd_s1 <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
				cmd_s1 <= dec;
			end else if (cmd_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/phcm_queue.sv
// Short command queue between the front end and the table engine of the pixel
// hit charge merger. Depends on phcm_pkg.
module phcm_queue #(
	parameter int QUEUE_DEPTH = phcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  phcm_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output phcm_pkg::cmd_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	phcm_pkg::cmd_t   slots [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/phcm_engine.sv
// Table engine of the pixel hit charge merger: searches and updates the pixel
// table, walks it on a flush and drives the result register. Depends on phcm_pkg.
module phcm_engine #(
	parameter int TABLE_DEPTH = phcm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  phcm_pkg::cmd_t                  cmd,
	input  logic [phcm_pkg::CHARGE_W-1:0]   threshold,
	output logic                            res_valid,
	input  logic                            res_ready,
	output phcm_pkg::result_t               res
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPEND,
		ST_FLUSH,
		ST_FLUSH_END
	} state_t;

	state_t              state_q;
	phcm_pkg::cmd_t      cmd_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	phcm_pkg::result_t   pend_q;
	logic                have_q;
	logic                out_valid_q;
	phcm_pkg::result_t   out_q;

	phcm_pkg::entry_t    table_mem [TABLE_DEPTH];
	phcm_pkg::entry_t    rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	phcm_pkg::entry_t    wr_data;

	logic                out_free;
	logic                at_end;
	logic [ADDR_W-1:0]   next_idx;
	logic                key_hit;
	logic                qualifies;
	logic                flush_adv;
	logic                emit_now;
	logic [phcm_pkg::CHARGE_W:0]   sum;
	logic [phcm_pkg::CHARGE_W-1:0] sat_sum;
	phcm_pkg::result_t   hit_res;
	phcm_pkg::result_t   end_res;

	assign out_free  = !out_valid_q || res_ready;
	assign at_end    = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign next_idx  = at_end ? '0 : idx_q + ADDR_W'(1);
	assign key_hit   = (rd_data_q.key == cmd_q.key);
	assign qualifies = (rd_data_q.charge > threshold);
	assign flush_adv = !qualifies || !have_q || out_free;
	assign sum       = {1'b0, rd_data_q.charge} + (phcm_pkg::CHARGE_W + 1)'(cmd_q.charge);
	assign sat_sum   = sum[phcm_pkg::CHARGE_W] ? phcm_pkg::CHARGE_MAX
	                                           : sum[phcm_pkg::CHARGE_W-1:0];

	// A result beat is loaded when a held pixel is pushed out by the next
	// qualifying one, or when the closing beat of a flush goes out.
	assign emit_now  = ((state_q == ST_FLUSH) && flush_adv && qualifies && have_q)
	                 || ((state_q == ST_FLUSH_END) && out_free);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		hit_res              = '0;
		hit_res.out_valid    = 1'b1;
		hit_res.key          = rd_data_q.key;
		hit_res.charge       = rd_data_q.charge;
		hit_res.first_source = rd_data_q.src;
		hit_res.overflowed   = ovf_q;
	end

	// The closing beat is the held pixel, or the empty marker when none qualified.
	always_comb begin
		end_res            = '0;
		end_res.overflowed = ovf_q;
		if (have_q) begin
			end_res = pend_q;
		end
		end_res.last = 1'b1;
	end

	always_comb begin
		case (state_q)
			ST_SEARCH: rd_addr = next_idx;
			ST_FLUSH:  rd_addr = flush_adv ? next_idx : idx_q;
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		case (state_q)
			ST_SEARCH: begin
				if (key_hit) begin
					wr_en          = 1'b1;
					wr_data.charge = sat_sum;
				end
			end
			ST_APPEND: begin
				wr_en          = (count_q != FULL_CNT);
				wr_addr        = count_q[ADDR_W-1:0];
				wr_data.key    = cmd_q.key;
				wr_data.charge = phcm_pkg::CHARGE_W'(cmd_q.charge);
				wr_data.src    = cmd_q.src;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						idx_q  <= '0;
						have_q <= 1'b0;
						if (cmd.op == phcm_pkg::OP_FLUSH) begin
							state_q <= (count_q == '0) ? ST_FLUSH_END : ST_FLUSH;
						end else begin
							state_q <= (count_q == '0) ? ST_APPEND : ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (key_hit) begin
						state_q <= ST_IDLE;
					end else if (at_end) begin
						state_q <= ST_APPEND;
					end else begin
						idx_q <= next_idx;
					end
				end
				ST_APPEND: begin
					if (count_q != FULL_CNT) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (flush_adv) begin
						if (qualifies) begin
							pend_q <= hit_res;
							have_q <= 1'b1;
							if (have_q) begin
								out_q <= pend_q;
							end
						end
						if (at_end) begin
							state_q <= ST_FLUSH_END;
						end else begin
							idx_q <= next_idx;
						end
					end
				end
				ST_FLUSH_END: begin
					if (out_free) begin
						out_q   <= end_res;
						count_q <= '0;
						ovf_q   <= 1'b0;
						have_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/pixel_hit_charge_merger_unit.sv
// Top level of the pixel hit charge merger: configuration register, beat packing
// and the front end, command queue and table engine. Depends on phcm_pkg,
// phcm_front, phcm_queue and phcm_engine.
//
//   Channel   Direction  Beat contents
//   s_*       in         tuser: operation; tdata: hit key, charge, mc_index
//   m_*       out        tuser: out_valid; tdata: pixel key, charge, source, flag;
//                        tlast: last result of a flush
//   APB       in/out     charge_threshold at byte address 0
//
// A hit occupies the table engine while it compares the stored entries (at most
// TABLE_DEPTH, none on an empty table) and then merges, appends or drops it; the
// single read port of the table memory, visited one entry per cycle, sets this.
// A flush walks the stored entries and then sends its closing beat, more slowly
// when the result side stalls. A command passes through the front end register
// and the queue on its way to the engine; both keep accepting beats while the
// engine works until the queue is full. The table needs no clearing pass after
// reset: only entries below the fill count are read.
module pixel_hit_charge_merger_unit #(
	parameter int TABLE_DEPTH = phcm_pkg::TABLE_DEPTH_DEF,
	parameter int QUEUE_DEPTH = phcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata from bit 0: sensor_id(12), front_end(4), column(7), row(7),
	// charge(20), mc_index(16), zero padding(6).
	input  logic [phcm_pkg::IN_DATA_W-1:0]    s_tdata,
	// tuser: operation (0 add hit, 1 flush).
	input  logic                              s_tuser,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata from bit 0: out_sensor_id(12), out_front_end(4), out_column(7),
	// out_row(7), out_charge(24), first_source(16), overflowed(1), zero(1).
	output logic [phcm_pkg::OUT_DATA_W-1:0]   m_tdata,
	// tuser: out_valid (1 carries a pixel, 0 empty flush marker).
	output logic                              m_tuser,
	output logic                              m_tlast,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [phcm_pkg::PADDR_W-1:0]      paddr,
	input  logic [phcm_pkg::PDATA_W-1:0]      pwdata,
	output logic [phcm_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	logic [phcm_pkg::CHARGE_W-1:0] threshold_q;
	logic                          fq_valid;
	logic                          fq_ready;
	phcm_pkg::cmd_t                fq_cmd;
	logic                          qe_valid;
	logic                          qe_ready;
	phcm_pkg::cmd_t                qe_cmd;
	phcm_pkg::result_t             res;
	phcm_pkg::out_beat_t           obeat;

	// The register file has a single register; the port never waits.
	assign pready = 1'b1;
	assign prdata = (paddr == phcm_pkg::REG_CHARGE_THRESHOLD)
	              ? phcm_pkg::PDATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (psel && penable && pwrite && pready
		             && (paddr == phcm_pkg::REG_CHARGE_THRESHOLD)) begin
			threshold_q <= pwdata[phcm_pkg::CHARGE_W-1:0];
		end
	end

	phcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	phcm_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qe_valid),
		.pop_ready  (qe_ready),
		.pop_data   (qe_cmd)
	);

	phcm_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qe_valid),
		.cmd_ready (qe_ready),
		.cmd       (qe_cmd),
		.threshold (threshold_q),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result register into the output beat.
	always_comb begin
		obeat              = '0;
		obeat.sensor_id    = res.key.sensor_id;
		obeat.front_end    = res.key.front_end;
		obeat.column       = res.key.column;
		obeat.row          = res.key.row;
		obeat.charge       = res.charge;
		obeat.first_source = res.first_source;
		obeat.overflowed   = res.overflowed;
	end

	assign m_tdata = phcm_pkg::OUT_DATA_W'(obeat);
	assign m_tuser = res.out_valid;
	assign m_tlast = res.last;

endmodule

>>> sim/phcm_checker.sv
// Result checker for the pixel hit charge merger: watches the input, result and
// configuration channels, predicts the result beats and compares them.
// Depends on phcm_pkg.
module phcm_checker
	import phcm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tuser,
	input  logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	input  logic                  pready,
	output int                    failures,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	// Shadow copy of the pixel table and the threshold register.
	key_t                table_key    [TABLE_DEPTH];
	logic [CHARGE_W-1:0] table_charge [TABLE_DEPTH];
	logic [SRC_W-1:0]    table_src    [TABLE_DEPTH];
	int                  fill_count;
	logic                overflow_flag;
	logic [CHARGE_W-1:0] threshold;
	result_t             pixel_results_due [$];

	initial begin
		failures      = 0;
		pending       = 0;
		fill_count    = 0;
		overflow_flag = 1'b0;
		threshold     = '0;
	end

	function automatic void merge_hit(in_beat_t b);
		key_t              k;
		logic [CHARGE_W:0] sum;
		bit                found;
		k.sensor_id = b.sensor_id;
		k.front_end = b.front_end;
		k.column    = b.column;
		k.row       = b.row;
		found       = 1'b0;
		for (int i = 0; i < fill_count; i++) begin
			if (!found && table_key[i] == k) begin
				sum             = table_charge[i] + b.charge;
				table_charge[i] = (sum > CHARGE_MAX) ? CHARGE_MAX : sum[CHARGE_W-1:0];
				found           = 1'b1;
			end
		end
		if (!found) begin
			if (fill_count < TABLE_DEPTH) begin
				table_key[fill_count]    = k;
				table_charge[fill_count] = CHARGE_W'(b.charge);
				table_src[fill_count]    = b.mc_index;
				fill_count++;
			end else begin
				overflow_flag = 1'b1;
			end
		end
	endfunction

	// Queues the flush results in table order; the final one carries last.
	function automatic void flush_table();
		result_t held;
		bit      have_held;
		have_held = 1'b0;
		held      = '0;
		for (int i = 0; i < fill_count; i++) begin
			if (table_charge[i] > threshold) begin
				if (have_held)
					pixel_results_due = {pixel_results_due, held};
				held.out_valid    = 1'b1;
				held.key          = table_key[i];
				held.charge       = table_charge[i];
				held.first_source = table_src[i];
				held.overflowed   = overflow_flag;
				held.last         = 1'b0;
				have_held         = 1'b1;
			end
		end
		if (!have_held) begin
			held            = '0;
			held.overflowed = overflow_flag;
		end
		held.last = 1'b1;
		pixel_results_due = {pixel_results_due, held};
		fill_count    = 0;
		overflow_flag = 1'b0;
	endfunction

	function automatic void compare_result(result_t want, out_beat_t got, logic got_valid,
			logic got_last);
		bit bad;
		bad = (got_valid !== want.out_valid) || (got.sensor_id !== want.key.sensor_id)
			|| (got.front_end !== want.key.front_end) || (got.column !== want.key.column)
			|| (got.row !== want.key.row) || (got.charge !== want.charge)
			|| (got.first_source !== want.first_source)
			|| (got.overflowed !== want.overflowed) || (got_last !== want.last)
			|| (got.pad !== 1'b0);
		if (bad) begin
			if (failures < MAX_REPORTS) begin
				$display("%0t: result beat mismatch", $time);
				$display("  want valid=%b key=%h/%h/%h/%h charge=%h src=%h ovf=%b last=%b",
					want.out_valid, want.key.sensor_id, want.key.front_end,
					want.key.column, want.key.row, want.charge, want.first_source,
					want.overflowed, want.last);
				$display("  got  valid=%b key=%h/%h/%h/%h charge=%h src=%h ovf=%b last=%b pad=%b",
					got_valid, got.sensor_id, got.front_end,
					got.column, got.row, got.charge, got.first_source, got.overflowed,
					got_last, got.pad);
			end
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count    = 0;
			overflow_flag = 1'b0;
			threshold     = '0;
			pixel_results_due.delete();
			pending       = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_CHARGE_THRESHOLD)
				threshold = pwdata[CHARGE_W-1:0];
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser) == OP_FLUSH)
					flush_table();
				else
					merge_hit(in_beat_t'(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (pixel_results_due.size() == 0) begin
					if (failures < MAX_REPORTS) begin
						$display("%0t: result beat with nothing expected", $time);
						$display("  tuser=%b tlast=%b tdata=%h", m_tuser, m_tlast, m_tdata);
					end
					failures++;
				end else begin
					compare_result(pixel_results_due.pop_front(), out_beat_t'(m_tdata),
						m_tuser, m_tlast);
				end
			end
			pending = pixel_results_due.size();
		end
	end

endmodule

>>> sim/tb_pixel_hit_charge_merger_unit.sv
// Testbench top for the pixel hit charge merger: clock, reset, hit and flush
// stimulus, result back-pressure, threshold writes and the verdict.
// Depends on phcm_pkg, pixel_hit_charge_merger_unit and phcm_checker.
module tb_pixel_hit_charge_merger_unit;
	import phcm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
	// Roughly the number of random beats offered after the directed part.
	localparam int RANDOM_BEATS  = 155;
	// A hit may compare every entry before it settles, so the wait grows with TABLE_DEPTH.
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
	// How long the result side holds off in the back-pressure round.
	localparam int HOLD_CYCLES   = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int failures;
	int pending;

	// Percentage chance that a beat, or a result-side burst, is preceded by idling.
	int idle_pct;
	// Set by the stimulus to ask the result side for one long hold-off.
	bit hold_results;
	int beats_sent;
	int directed_beats;

	pixel_hit_charge_merger_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	phcm_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.failures(failures),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A fixed time limit; a run that reaches it is declared hung and failed.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result side. Ready comes in bursts of random length, broken by idle bursts
	// while idling is enabled. When the stimulus asks for it, ready is held low
	// for a long counted stretch so that the table engine stalls on its output,
	// the command queue fills and the input stalls too.
	initial begin : result_sink
		int span;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_results = 1'b0;
			end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
				span = $urandom_range(1, 18);
				m_tready <= 1'b0;
				repeat (span - 1) @(negedge clk);
			end else begin
				span = $urandom_range(1, 24);
				m_tready <= 1'b1;
				repeat (span - 1) @(negedge clk);
			end
		end
	end

	function automatic key_t random_key();
		key_t k;
		k.sensor_id = SENSOR_W'($urandom);
		k.front_end = FE_W'($urandom);
		k.column    = COL_W'($urandom);
		k.row       = ROW_W'($urandom);
		return k;
	endfunction

	// Hit charges lean towards the extremes as well as the full range.
	function automatic logic [HIT_Q_W-1:0] random_charge();
		case ($urandom_range(0, 4))
			0:       return HIT_Q_W'($urandom_range(0, 15));
			1:       return {HIT_Q_W{1'b1}};
			default: return HIT_Q_W'($urandom);
		endcase
	endfunction

	function automatic logic [CHARGE_W-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CHARGE_MAX;
			2:       return CHARGE_W'($urandom_range(0, 100));
			3:       return CHARGE_W'($urandom);
			default: return CHARGE_W'($urandom_range(0, 1 << HIT_Q_W));
		endcase
	endfunction

	// Offers one beat and returns once it has been taken. The valid line stays
	// high between back-to-back beats; an idle burst, when drawn, lowers it first.
	task automatic send_beat(op_t op, key_t k, logic [HIT_Q_W-1:0] q, logic [SRC_W-1:0] src);
		in_beat_t b;
		int       gap;
		b.pad       = '0;
		b.sensor_id = k.sensor_id;
		b.front_end = k.front_end;
		b.column    = k.column;
		b.row       = k.row;
		b.charge    = q;
		b.mc_index  = src;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic send_hit(key_t k, logic [HIT_Q_W-1:0] q, logic [SRC_W-1:0] src);
		send_beat(OP_HIT, k, q, src);
	endtask

	// A flush ignores its data, so the data carries noise.
	task automatic send_flush();
		send_beat(OP_FLUSH, random_key(), random_charge(), SRC_W'($urandom));
	endtask

	// Waits until every expected result has been seen and the engine has had
	// time to finish any hit still in flight.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup cycle then access cycle; the register takes the value at the edge
	// where the access completes.
	task automatic set_threshold(logic [CHARGE_W-1:0] value);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_CHARGE_THRESHOLD;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// An ordinary event: hits drawn from a small pool of pixels, so that many of
	// them merge, with the odd stray pixel, then a flush.
	task automatic run_event(int hits);
		key_t pool [8];
		int   pool_size;
		pool_size = $urandom_range(1, 8);
		for (int i = 0; i < 8; i++)
			pool[i] = random_key();
		for (int n = 0; n < hits; n++) begin
			if ($urandom_range(0, 3) == 0)
				send_hit(random_key(), random_charge(), SRC_W'($urandom));
			else
				send_hit(pool[$urandom_range(0, pool_size - 1)], random_charge(),
					SRC_W'($urandom));
		end
		send_flush();
	endtask

	// Fills every entry of the table, offers new pixels that must be dropped
	// and raise the overflow flag, merges into the first and last entries, and
	// flushes.
	task automatic run_full_table();
		key_t keys [TABLE_DEPTH];
		key_t stray;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			keys[i]     = random_key();
			keys[i].row = ROW_W'(i);
			send_hit(keys[i], random_charge(), SRC_W'($urandom));
		end
		for (int i = 0; i < 4; i++) begin
			stray     = random_key();
			stray.row = ROW_W'(TABLE_DEPTH + i);
			send_hit(stray, random_charge(), SRC_W'($urandom));
		end
		send_hit(keys[0], {HIT_Q_W{1'b1}}, SRC_W'($urandom));
		send_hit(keys[TABLE_DEPTH - 1], random_charge(), SRC_W'($urandom));
		send_flush();
	endtask

	// One pixel is hit at full charge until the 24-bit sum clamps; a second
	// pixel stays below the threshold, which sits one below the clamp value.
	task automatic run_saturation();
		key_t hot;
		hot = random_key();
		for (int i = 0; i < 18; i++) begin
			send_hit(hot, {HIT_Q_W{1'b1}}, SRC_W'($urandom));
			if (i == 3)
				send_hit(random_key(), random_charge(), SRC_W'($urandom));
		end
		send_flush();
	endtask

	// Flushes queue up behind a stalled result side until the input stalls.
	task automatic run_backpressure();
		hold_results = 1'b1;
		for (int r = 0; r < 4; r++) begin
			for (int n = 0; n < 3; n++)
				send_hit(random_key(), random_charge(), SRC_W'($urandom));
			send_flush();
		end
	endtask

	initial begin : stimulus
		key_t hi_key;
		key_t lo_key;
		key_t mid_key;
		int   round;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= OP_HIT;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		idle_pct     = 20;
		hold_results = 1'b0;
		beats_sent   = 0;
		hi_key       = '1;
		lo_key       = '0;
		mid_key      = {12'h5A5, 4'hA, 7'h55, 7'h2A};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, threshold at its reset value of zero. An empty table
		// flushes to the single empty marker. A zero-charge pixel is never
		// emitted, and a merge keeps the source index of the first hit.
		send_flush();
		send_hit(hi_key, {HIT_Q_W{1'b1}}, {SRC_W{1'b1}});
		send_hit(lo_key, '0, '0);
		send_hit(lo_key, HIT_Q_W'(1), SRC_W'(16'h1234));
		send_hit(mid_key, '0, SRC_W'(16'hA5A5));
		send_hit(hi_key, {HIT_Q_W{1'b1}}, SRC_W'(16'h5A5A));
		send_flush();

		// The threshold test is strict: a charge equal to it is held back,
		// one above it goes out, and a merge can lift a pixel over it.
		set_threshold(CHARGE_W'(1000));
		send_hit(lo_key, HIT_Q_W'(1000), SRC_W'(1));
		send_hit(hi_key, HIT_Q_W'(1001), SRC_W'(2));
		send_hit(mid_key, HIT_Q_W'(999), SRC_W'(3));
		send_hit(mid_key, HIT_Q_W'(2), SRC_W'(4));
		send_flush();

		// Nothing can exceed the largest threshold, so only the marker appears.
		set_threshold(CHARGE_MAX);
		send_hit(random_key(), {HIT_Q_W{1'b1}}, SRC_W'($urandom));
		send_flush();
		directed_beats = beats_sent;

		// Random part. Special rounds come early; idling varies from round to
		// round, and the closing stretch runs with none on either side.
		round = 0;
		while (beats_sent - directed_beats < RANDOM_BEATS) begin
			if (beats_sent - directed_beats >= RANDOM_BEATS - 35)
				idle_pct = 0;
			else
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 15;
					default: idle_pct = 50;
				endcase
			case (round)
				1: begin
					set_threshold(CHARGE_W'(1 << (HIT_Q_W - 1)));
					run_full_table();
				end
				3: begin
					set_threshold(CHARGE_MAX - 1);
					run_saturation();
				end
				5: begin
					idle_pct = 0;
					run_backpressure();
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						set_threshold(pick_threshold());
					run_event($urandom_range(0, 10));
				end
			endcase
			round++;
		end

		drain();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
